>>> sv/lbpc_pkg.sv
package lbpc_pkg;

  localparam int NUM_LEDS = 4;
  localparam int POS_W    = $clog2(NUM_LEDS);
  localparam int IDX_W    = 3;
  localparam int OP_W     = 4;
  localparam int PAT_W    = 4;
  localparam int DUR_W    = 32;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 8;

  // Field offsets inside in_tdata
  localparam int IN_OP_LSB  = 0;
  localparam int IN_IDX_LSB = IN_OP_LSB + OP_W;
  localparam int IN_PAT_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_ON_LSB  = IN_PAT_LSB + PAT_W;
  localparam int IN_OFF_LSB = IN_ON_LSB + DUR_W;

  typedef logic [NUM_LEDS-1:0] led_vec_t;

  typedef enum logic [OP_W-1:0] {
    OP_ON          = 4'd0,
    OP_OFF         = 4'd1,
    OP_TOGGLE      = 4'd2,
    OP_PATTERN     = 4'd3,
    OP_CHASE       = 4'd4,
    OP_SCANNER     = 4'd5,
    OP_BLINK_START = 4'd6,
    OP_BLINK_STOP  = 4'd7,
    OP_TICK        = 4'd8,
    OP_UPDATE      = 4'd9
  } op_t;

  // Per-LED blink channel control
  typedef struct packed {
    logic start;
    logic stop;
    logic update;
  } blink_ctrl_t;

  // Drive change requested by a blink channel on update
  typedef struct packed {
    logic set_led;
    logic clr_led;
  } blink_evt_t;

endpackage

>>> sv/lbpc_blink_chan.sv
module lbpc_blink_chan #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbpc_pkg::blink_ctrl_t   ctrl,
  input  logic [TIME_WIDTH-1:0]   on_len,
  input  logic [TIME_WIDTH-1:0]   off_len,
  input  logic [TIME_WIDTH-1:0]   now_ticks,
  output lbpc_pkg::blink_evt_t    evt
);
  import lbpc_pkg::*;

  logic [TIME_WIDTH-1:0] on_len_r;
  logic [TIME_WIDTH-1:0] off_len_r;
  logic [TIME_WIDTH-1:0] phase_start_r;
  logic                  phase_on_r;
  logic                  active_r;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  on_done;
  logic                  off_done;

  // Elapsed time wraps with the tick counter
  assign elapsed  = now_ticks - phase_start_r;
  assign on_done  = ctrl.update && active_r && phase_on_r && (elapsed >= on_len_r);
  assign off_done = ctrl.update && active_r && !phase_on_r && (elapsed >= off_len_r);

  assign evt.clr_led = on_done;
  assign evt.set_led = off_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      phase_on_r <= 1'b0;
    end else if (ctrl.start) begin
      on_len_r      <= on_len;
      off_len_r     <= off_len;
      phase_start_r <= now_ticks;
      phase_on_r    <= 1'b1;
      active_r      <= 1'b1;
    end else if (ctrl.stop) begin
      active_r <= 1'b0;
    end else if (on_done || off_done) begin
      phase_start_r <= now_ticks;
      phase_on_r    <= off_done;
    end
  end

endmodule

>>> sv/led_blink_pattern_controller_core.sv
// Pipeline: a request accepted into the input stage is executed there and its result
// is loaded into the result register that drives out_tdata (one input stage, then the
// result register); a stalled output holds both stages.
// Throughput: one request per cycle; the command stage and the result register
// advance together, so only out_tready holds the flow.
// Reset (rst_n low, synchronous): all LEDs off, tick clock zero, no LED blinking,
// chase and scanner at LED 0 with the scanner moving up, both stages empty.
module led_blink_pattern_controller_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // opcode[3:0], led_index[6:4], pattern_bits[10:7], on_duration[42:11],
  // off_duration[74:43], zero pad [79:75]
  input  logic [lbpc_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // led_bits[3:0], addressed_lit[4], zero pad [7:5]
  output logic [lbpc_pkg::OUT_W-1:0]  out_tdata
);
  import lbpc_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_LEDS - 1);

  // Input stage
  logic                in_v_r;
  logic [IN_W-1:0]     in_data_r;

  // Result register
  logic                out_valid_r;
  logic [NUM_LEDS-1:0] out_bits_r;
  logic                out_lit_r;

  // Architectural state
  led_vec_t              drive_r, drive_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [POS_W-1:0]      chase_r, chase_nxt;
  logic [POS_W-1:0]      scan_r, scan_nxt, scan_step;
  logic                  scan_down_r, scan_down_nxt;

  logic                  advance;
  logic                  fire;

  op_t                   op;
  logic [IDX_W-1:0]      idx;
  logic [PAT_W-1:0]      pat;
  logic [TIME_WIDTH-1:0] on_d;
  logic [TIME_WIDTH-1:0] off_d;
  logic                  one;
  logic                  all;
  led_vec_t              idx_bit;
  logic                  start_ok;
  led_vec_t              set_vec;
  led_vec_t              clr_vec;
  logic                  lit_nxt;

  blink_ctrl_t           ctrl [NUM_LEDS];
  blink_evt_t            evt  [NUM_LEDS];

  // Result register free or draining: both stages move together
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign fire      = in_v_r && advance;

  // Unpack the held request
  assign op    = op_t'(in_data_r[IN_OP_LSB +: OP_W]);
  assign idx   = in_data_r[IN_IDX_LSB +: IDX_W];
  assign pat   = in_data_r[IN_PAT_LSB +: PAT_W];
  assign on_d  = TIME_WIDTH'(in_data_r[IN_ON_LSB +: DUR_W]);
  assign off_d = TIME_WIDTH'(in_data_r[IN_OFF_LSB +: DUR_W]);

  assign one      = (idx < IDX_W'(NUM_LEDS));
  assign all      = (idx == IDX_W'(NUM_LEDS));
  assign idx_bit  = one ? (led_vec_t'(1) << idx[POS_W-1:0]) : '0;
  assign start_ok = one && (on_d != '0) && (off_d != '0);

  // One blink timer per LED; all compare in parallel on update
  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_chan
    assign ctrl[g].start  = fire && (op == OP_BLINK_START) && start_ok && idx_bit[g];
    assign ctrl[g].stop   = fire && (op == OP_BLINK_STOP) && idx_bit[g];
    assign ctrl[g].update = fire && (op == OP_UPDATE);

    lbpc_blink_chan #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .on_len    (on_d),
      .off_len   (off_d),
      .now_ticks (now_r),
      .evt       (evt[g])
    );

    assign set_vec[g] = evt[g].set_led;
    assign clr_vec[g] = evt[g].clr_led;
  end

  // Scanner: step, then reverse on reaching either end
  assign scan_step = scan_down_r ? (scan_r - POS_W'(1)) : (scan_r + POS_W'(1));

  always_comb begin
    drive_nxt     = drive_r;
    now_nxt       = now_r;
    chase_nxt     = chase_r;
    scan_nxt      = scan_r;
    scan_down_nxt = scan_down_r;
    unique case (op)
      OP_ON: begin
        if (all) drive_nxt = '1;
        else     drive_nxt = drive_r | idx_bit;
      end
      OP_OFF: begin
        if (all) drive_nxt = '0;
        else     drive_nxt = drive_r & ~idx_bit;
      end
      OP_TOGGLE: begin
        if (all) drive_nxt = ~drive_r;
        else     drive_nxt = drive_r ^ idx_bit;
      end
      OP_PATTERN: begin
        drive_nxt = led_vec_t'(pat);
      end
      OP_CHASE: begin
        drive_nxt = led_vec_t'(1) << chase_r;
        chase_nxt = (chase_r == LAST_POS) ? '0 : chase_r + POS_W'(1);
      end
      OP_SCANNER: begin
        drive_nxt = led_vec_t'(1) << scan_r;
        scan_nxt  = scan_step;
        if (scan_step == '0 || scan_step == LAST_POS) scan_down_nxt = !scan_down_r;
      end
      OP_BLINK_START: begin
        if (start_ok) drive_nxt = drive_r | idx_bit;
      end
      OP_BLINK_STOP: begin
        drive_nxt = drive_r & ~idx_bit;
      end
      OP_TICK: begin
        now_nxt = now_r + TIME_WIDTH'(1);
      end
      OP_UPDATE: begin
        drive_nxt = (drive_r | set_vec) & ~clr_vec;
      end
      default: begin
        // unused opcodes: report state only
      end
    endcase
  end

  assign lit_nxt = one && drive_nxt[idx[POS_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      drive_r     <= '0;
      now_r       <= '0;
      chase_r     <= '0;
      scan_r      <= '0;
      scan_down_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (advance) out_valid_r <= in_v_r;
      if (fire) begin
        drive_r     <= drive_nxt;
        now_r       <= now_nxt;
        chase_r     <= chase_nxt;
        scan_r      <= scan_nxt;
        scan_down_r <= scan_down_nxt;
      end
    end
  end

  // Payload registers: input loads on accept, result on execute; both hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata;
    if (fire) begin
      out_bits_r <= drive_nxt;
      out_lit_r  <= lit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - NUM_LEDS - 1)'(0), out_lit_r, out_bits_r};

`ifndef SYNTH
  // A request leaving the input stage always lands in the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("executed request produced no result");

  // Addressed LED reported lit implies some LED is driven
  a_lit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[NUM_LEDS]) |-> (out_tdata[NUM_LEDS-1:0] != '0))
    else $error("addressed_lit set with all LEDs off");

  // Chase and scanner light exactly one LED
  a_single_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op == OP_CHASE || op == OP_SCANNER)) |=> $onehot(out_tdata[NUM_LEDS-1:0]))
    else $error("chase or scanner result not one-hot");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lbpc_pkg::*;

  localparam int TW = 32;
  localparam int RANDOM_REQUESTS = 1024;
  // Drop all idling for this many requests at the end of the run
  localparam int CALM_TAIL = 150;
  // Drain the pipeline once, completely, at this point of the random part
  localparam int DRAIN_POINT = 500;
  // Two register stages between the request and the result, plus margin
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  localparam logic [IDX_W-1:0] IDX_ALL  = IDX_W'(NUM_LEDS);
  localparam logic [IDX_W-1:0] IDX_BAD5 = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_BAD6 = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_BAD7 = IDX_W'(7);
  // Opcodes with no function; they only report the LED state
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  // One command as it travels on in_tdata
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [PAT_W-1:0] pat;
    logic [DUR_W-1:0] on_len;
    logic [DUR_W-1:0] off_len;
  } led_cmd_t;

  // LED state reported for one command
  typedef struct {
    led_vec_t leds;
    logic     lit;
  } led_report_t;

  // Directed request; the fixed report is used only where known_report is set
  typedef struct {
    led_cmd_t    cmd;
    logic        known_report;
    led_report_t report;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  // Own copy of the controller state
  led_vec_t          drive_q;
  logic [TW-1:0]     tick_now;
  logic [TW-1:0]     on_len_q [NUM_LEDS];
  logic [TW-1:0]     off_len_q [NUM_LEDS];
  logic [TW-1:0]     phase_t0 [NUM_LEDS];
  logic [NUM_LEDS-1:0] in_on_phase;
  logic [NUM_LEDS-1:0] blinking;
  logic [POS_W-1:0]  chase_at;
  logic [POS_W-1:0]  scan_at;
  logic              scan_down;

  led_report_t pending_reports [$];
  directed_row_t directed_rows [$];
  int mismatch_count;
  int reports_seen;
  bit idling_on;

  led_blink_pattern_controller_core #(
    .TIME_WIDTH(TW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the local LED state and return what it reports.
  task apply_led_command(input led_cmd_t c, output led_report_t r);
    logic one;
    logic all;
    logic [POS_W-1:0] pos;
    logic [TW-1:0] elapsed;
    one = c.idx < NUM_LEDS;
    all = c.idx == IDX_ALL;
    pos = c.idx[POS_W-1:0];
    case (c.op)
      OP_ON: begin
        if (one) drive_q[pos] = 1'b1;
        else if (all) drive_q = '1;
      end
      OP_OFF: begin
        if (one) drive_q[pos] = 1'b0;
        else if (all) drive_q = '0;
      end
      OP_TOGGLE: begin
        if (one) drive_q[pos] = ~drive_q[pos];
        else if (all) drive_q = ~drive_q;
      end
      OP_PATTERN: begin
        drive_q = c.pat[NUM_LEDS-1:0];
      end
      OP_CHASE: begin
        // One LED lit, position wraps around the row
        drive_q = '0;
        drive_q[chase_at] = 1'b1;
        chase_at = chase_at + POS_W'(1);
      end
      OP_SCANNER: begin
        // Reverse direction on reaching either end of the row
        drive_q = '0;
        drive_q[scan_at] = 1'b1;
        if (scan_down) scan_at = scan_at - POS_W'(1);
        else scan_at = scan_at + POS_W'(1);
        if (scan_at == '0 || scan_at == POS_W'(NUM_LEDS - 1)) scan_down = ~scan_down;
      end
      OP_BLINK_START: begin
        if (one && c.on_len != 0 && c.off_len != 0) begin
          on_len_q[pos]    = c.on_len;
          off_len_q[pos]   = c.off_len;
          phase_t0[pos]    = tick_now;
          in_on_phase[pos] = 1'b1;
          blinking[pos]    = 1'b1;
          drive_q[pos]     = 1'b1;
        end
      end
      OP_BLINK_STOP: begin
        if (one) begin
          blinking[pos] = 1'b0;
          drive_q[pos]  = 1'b0;
        end
      end
      OP_TICK: begin
        tick_now = tick_now + TW'(1);
      end
      OP_UPDATE: begin
        // Flip each blinking LED whose current phase has run out
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (blinking[i]) begin
            elapsed = tick_now - phase_t0[i];
            if (in_on_phase[i]) begin
              if (elapsed >= on_len_q[i]) begin
                drive_q[i]     = 1'b0;
                in_on_phase[i] = 1'b0;
                phase_t0[i]    = tick_now;
              end
            end else if (elapsed >= off_len_q[i]) begin
              drive_q[i]     = 1'b1;
              in_on_phase[i] = 1'b1;
              phase_t0[i]    = tick_now;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.leds = drive_q;
    r.lit  = one ? drive_q[pos] : 1'b0;
  endtask

  // Present one request, hold it until accepted, then queue its report.
  task send_request(input led_cmd_t c, input logic known, input led_report_t fixed);
    int gap;
    led_report_t predicted;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {5'b0, c.off_len, c.on_len, c.pat, c.idx, c.op};
    do @(posedge clk); while (!in_tready);
    apply_led_command(c, predicted);
    pending_reports.push_back(known ? fixed : predicted);
  endtask

  function automatic led_cmd_t random_command();
    led_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) c.op = OP_ON;
    else if (pick < 14) c.op = OP_OFF;
    else if (pick < 22) c.op = OP_TOGGLE;
    else if (pick < 28) c.op = OP_PATTERN;
    else if (pick < 34) c.op = OP_CHASE;
    else if (pick < 40) c.op = OP_SCANNER;
    else if (pick < 50) c.op = OP_BLINK_START;
    else if (pick < 54) c.op = OP_BLINK_STOP;
    else if (pick < 77) c.op = OP_TICK;
    else if (pick < 96) c.op = OP_UPDATE;
    else c.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    // Mostly valid LEDs or all, now and then an index past the end
    if ($urandom_range(0, 9) < 8) c.idx = IDX_W'($urandom_range(0, NUM_LEDS));
    else c.idx = IDX_W'($urandom_range(IDX_BAD5, IDX_BAD7));
    c.pat = PAT_W'($urandom_range(0, 15));
    c.on_len  = $urandom();
    c.off_len = $urandom();
    if (c.op == OP_BLINK_START) begin
      // Short phases so that updates actually fire; some zero, some huge
      pick = $urandom_range(0, 99);
      if (pick < 80) c.on_len = DUR_W'($urandom_range(1, 6));
      else if (pick < 90) c.on_len = '0;
      pick = $urandom_range(0, 99);
      if (pick < 80) c.off_len = DUR_W'($urandom_range(1, 6));
      else if (pick < 90) c.off_len = '0;
    end
    return c;
  endfunction

  // Result side: stall in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Compare every accepted result with the oldest queued report.
  always @(posedge clk) begin
    led_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: result %0d arrived with no request waiting, data 0x%02h",
                   reports_seen, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[NUM_LEDS-1:0] !== want.leds || out_tdata[NUM_LEDS] !== want.lit) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d: led_bits exp %b got %b, addressed_lit exp %b got %b",
                     reports_seen, want.leds, out_tdata[NUM_LEDS-1:0], want.lit,
                     out_tdata[NUM_LEDS]);
        end
      end
    end
  end

  // Stimulus: directed table first, then random requests.
  initial begin
    led_cmd_t c;
    led_report_t none;
    mismatch_count = 0;
    reports_seen   = 0;
    idling_on      = 1'b1;
    none           = '{leds: '0, lit: 1'b0};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    drive_q     = '0;
    tick_now    = '0;
    in_on_phase = '0;
    blinking    = '0;
    chase_at    = '0;
    scan_at     = '0;
    scan_down   = 1'b0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      on_len_q[i]  = '0;
      off_len_q[i] = '0;
      phase_t0[i]  = '0;
    end

    // Fresh out of reset, everything off
    directed_rows.push_back('{'{OP_UPDATE, 3'd0, 4'h0, 32'd0, 32'd0}, 1'b1, '{4'h0, 1'b0}});
    // All-LED forms of on and toggle, plus single-LED off and toggle
    directed_rows.push_back('{'{OP_ON, IDX_ALL, 4'h0, 32'd0, 32'd0}, 1'b1, '{4'hF, 1'b0}});
    directed_rows.push_back('{'{OP_OFF, 3'd2, 4'h0, 32'd0, 32'd0}, 1'b1, '{4'hB, 1'b0}});
    directed_rows.push_back('{'{OP_TOGGLE, IDX_ALL, 4'h0, 32'd0, 32'd0}, 1'b1, '{4'h4, 1'b0}});
    directed_rows.push_back('{'{OP_TOGGLE, 3'd2, 4'h0, 32'd0, 32'd0}, 1'b1, '{4'h0, 1'b0}});
    // Index past the end leaves the LEDs alone; pattern applies whatever the index
    directed_rows.push_back('{'{OP_ON, IDX_BAD7, 4'hF, 32'd0, 32'd0}, 1'b1, '{4'h0, 1'b0}});
    directed_rows.push_back('{'{OP_PATTERN, 3'd3, 4'hF, 32'd0, 32'd0}, 1'b1, '{4'hF, 1'b1}});
    directed_rows.push_back('{'{OP_PATTERN, IDX_ALL, 4'h0, DUR_MAX, DUR_MAX}, 1'b1,
                               '{4'h0, 1'b0}});
    // Chase and scanner ignore index and pattern; run the scanner to its top end
    directed_rows.push_back('{'{OP_CHASE, IDX_BAD7, 4'hF, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_CHASE, 3'd0, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_SCANNER, 3'd1, 4'hA, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_SCANNER, 3'd2, 4'h5, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_SCANNER, 3'd3, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    // Blink starts that must be dropped: zero phase, bad index, all index
    directed_rows.push_back('{'{OP_BLINK_START, 3'd0, 4'h0, 32'd0, 32'd5}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_START, 3'd0, 4'h0, DUR_MAX, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_START, IDX_BAD5, 4'h0, 32'd1, 32'd1}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_START, IDX_ALL, 4'h0, 32'd1, 32'd1}, 1'b0, none});
    // Real blinkers, then let LED 1 time out and override it by hand
    directed_rows.push_back('{'{OP_BLINK_START, 3'd1, 4'h0, 32'd1, 32'd2}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_START, 3'd3, 4'h0, DUR_MAX, DUR_MAX}, 1'b0, none});
    directed_rows.push_back('{'{OP_TICK, 3'd1, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_UPDATE, 3'd1, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_TOGGLE, 3'd1, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_TICK, 3'd3, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_STOP, 3'd1, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    directed_rows.push_back('{'{OP_BLINK_STOP, IDX_BAD6, 4'h0, 32'd0, 32'd0}, 1'b0, none});
    // Spare opcode just reports the state
    directed_rows.push_back('{'{OP_SPARE_LAST, 3'd3, 4'hF, DUR_MAX, DUR_MAX}, 1'b0, none});

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].known_report,
                   directed_rows[i].report);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == DRAIN_POINT) begin
        // Hold off the sender until every queued report has come back
        @(negedge clk);
        in_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_REQUESTS - CALM_TAIL) idling_on = 1'b0;
      c = random_command();
      send_request(c, 1'b0, none);
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
